// ===== hw/rtl/savings_route_merge_macros.svh =====
// assertion macros for the rtl files
`ifndef SAVINGS_ROUTE_MERGE_MACROS_SVH
`define SAVINGS_ROUTE_MERGE_MACROS_SVH

`ifndef SYNTHESIS

// checked while reset is released
`define SRM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("savings_route_merge assertion failed");

// checked on every edge, reset included
`define SRM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("savings_route_merge assertion failed");

`else

`define SRM_ASSERT(label, clk, rst_n, prop)
`define SRM_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== hw/rtl/srm_pkg.sv =====
`timescale 1ns / 1ps

package srm_pkg;

  localparam int unsigned NUM_NODES = 64;
  localparam int unsigned NODE_W    = $clog2(NUM_NODES);
  localparam int unsigned STEP_W    = $clog2(NUM_NODES + 1);
  localparam int unsigned NBR_W     = 2 * NODE_W;
  localparam int unsigned DEM_W     = 16;
  localparam int unsigned ACC_W     = 17;
  localparam int unsigned CAP_W     = 17;
  localparam int unsigned SAV_W     = 24;
  localparam int unsigned TOT_W     = 32;
  localparam int unsigned STAT_W    = 4;

  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(65535);
  localparam logic [ACC_W-1:0] DEMAND_SAT = '1;
  localparam logic [TOT_W-1:0] TOTAL_SAT  = '1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_MERGE = 1'b1;

  localparam logic [STAT_W-1:0] ST_MERGED   = 4'd0;
  localparam logic [STAT_W-1:0] ST_FEASIBLE = 4'd1;
  localparam logic [STAT_W-1:0] ST_INTERIOR = 4'd2;
  localparam logic [STAT_W-1:0] ST_LINKED   = 4'd3;
  localparam logic [STAT_W-1:0] ST_SAME     = 4'd4;
  localparam logic [STAT_W-1:0] ST_OVER_CAP = 4'd5;
  localparam logic [STAT_W-1:0] ST_NONPOS   = 4'd6;
  localparam logic [STAT_W-1:0] ST_LOADED   = 4'd7;
  localparam logic [STAT_W-1:0] ST_INVALID  = 4'd8;

endpackage

// ===== hw/rtl/srm_ram.sv =====
`timescale 1ns / 1ps

module srm_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/savings_route_merge.sv =====
`timescale 1ns / 1ps
// channel  | direction | handshake                  | payload
// in       | input     | in_valid_i / in_stall_o    | operation, node_a, node_b,
//          |           |                            | demand_value, saving, apply_if_feasible
// out      | output    | out_valid_o / out_stall_i  | status, route_demand, total_saved
// cfg      | input     | cfg_valid_i / cfg_ready_o  | vehicle_capacity
//
// a load goes straight to FINISH; a merge with bad operands does too, an interior or linked one after RD_A and RD_B
// a merge that walks both routes runs RD_A, RD_B, WALK_A, WALK_B and DECIDE, then WR_A and
// WR_B when it commits; one neighbor table read per visited node through the shared demand adder
// longest item: both walks over one 63-node route
// reset clears per-entry valid bits at once: no clearing pass
// one item at a time; a result waiting on out_stall_i holds the sequencer

`include "savings_route_merge_macros.svh"

module savings_route_merge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [srm_pkg::NODE_W-1:0]  node_a_i,
  input  logic [srm_pkg::NODE_W-1:0]  node_b_i,
  input  logic [srm_pkg::DEM_W-1:0]   demand_value_i,
  input  logic signed [srm_pkg::SAV_W-1:0] saving_i,
  input  logic                        apply_if_feasible_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [srm_pkg::STAT_W-1:0]  status_o,
  output logic [srm_pkg::ACC_W-1:0]   route_demand_o,
  output logic [srm_pkg::TOT_W-1:0]   total_saved_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [srm_pkg::CAP_W-1:0]   cfg_vehicle_capacity_i
);

  import srm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_A, S_RD_B, S_WALK_A, S_WALK_B, S_DECIDE, S_WR_A, S_WR_B, S_FINISH
  } state_e;

  localparam logic [NODE_W:0]   NODE_LIM = (NODE_W + 1)'(NUM_NODES);
  localparam logic [STEP_W-1:0] STEP_LIM = STEP_W'(NUM_NODES);

  state_e state_q;

  logic [NODE_W-1:0] a_q, b_q, node_q, prev_q, rd_addr_d;
  logic [NODE_W-1:0] a0_q, a1_q, b0_q, b1_q, end_a_q, end_b_q;
  logic              sa_q, sb_q, first_q, apply_q;
  logic [STEP_W-1:0] steps_q;
  logic [SAV_W-1:0]  saving_q;
  logic [ACC_W-1:0]  acc_q;
  logic [TOT_W-1:0]  total_q;
  logic [CAP_W-1:0]  cap_q;
  logic [STAT_W-1:0] status_q;
  logic [NUM_NODES-1:0] nbr_vld_q, dem_vld_q;

  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q;
  logic [ACC_W-1:0]  out_demand_q;
  logic [TOT_W-1:0]  out_total_q;

  logic [NBR_W-1:0]  nbr_rdata, nbr_wdata;
  logic [NODE_W-1:0] nbr_waddr;
  logic              nbr_we;
  logic [DEM_W-1:0]  dem_rdata;
  logic              dem_we;

  logic [NODE_W-1:0] nb0, nb1, walk_next, a_other, b_other;
  logic [DEM_W-1:0]  dem;
  logic [ACC_W:0]    acc_sum;
  logic [ACC_W-1:0]  acc_sat;
  logic [STEP_W-1:0] steps_nxt;
  logic              walk_cont, in_xfer, a_range_ok, merge_bad, sav_pos;
  logic [TOT_W:0]    tot_sum;
  logic [TOT_W-1:0]  tot_sat;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign a_range_ok = ({1'b0, node_a_i} < NODE_LIM);
  assign merge_bad  = (node_a_i == '0) || (node_b_i == '0) || (node_a_i == node_b_i) ||
                      !a_range_ok || ({1'b0, node_b_i} >= NODE_LIM);

  // entries never written read as zero
  assign nb0 = nbr_vld_q[node_q] ? nbr_rdata[NODE_W-1:0] : '0;
  assign nb1 = nbr_vld_q[node_q] ? nbr_rdata[NBR_W-1:NODE_W] : '0;
  assign dem = dem_vld_q[node_q] ? dem_rdata : '0;

  // shared saturating demand adder
  assign acc_sum = {1'b0, acc_q} + {(ACC_W + 1 - DEM_W)'(0), dem};
  assign acc_sat = acc_sum[ACC_W] ? DEMAND_SAT : acc_sum[ACC_W-1:0];

  assign walk_next = first_q ? ((nb0 != '0) ? nb0 : nb1)
                             : ((nb0 == prev_q) ? nb1 : nb0);
  assign steps_nxt = first_q ? steps_q : steps_q + STEP_W'(1);
  assign walk_cont = (walk_next != node_q) && (walk_next != '0) &&
                     ({1'b0, walk_next} < NODE_LIM) && (steps_nxt < STEP_LIM);

  assign a_other = (a0_q == '0) ? a1_q : a0_q;
  assign b_other = (nb0 == '0) ? nb1 : nb0;

  assign sav_pos = !saving_q[SAV_W-1] && (saving_q != '0);
  assign tot_sum = {1'b0, total_q} + {(TOT_W + 1 - SAV_W)'(0), saving_q};
  assign tot_sat = tot_sum[TOT_W] ? TOTAL_SAT : tot_sum[TOT_W-1:0];

  always_comb begin
    rd_addr_d = node_q;
    nbr_we    = 1'b0;
    nbr_waddr = a_q;
    nbr_wdata = sa_q ? {b_q, a0_q} : {a1_q, b_q};
    dem_we    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && operation_i == OP_MERGE) rd_addr_d = node_a_i;
        dem_we = in_xfer && operation_i == OP_LOAD && a_range_ok;
      end
      S_RD_A:   rd_addr_d = b_q;
      S_RD_B:   rd_addr_d = a_q;
      S_WALK_A: rd_addr_d = walk_cont ? walk_next : b_q;
      S_WALK_B: rd_addr_d = walk_cont ? walk_next : node_q;
      S_WR_A:   nbr_we = 1'b1;
      S_WR_B: begin
        nbr_we    = 1'b1;
        nbr_waddr = b_q;
        nbr_wdata = sb_q ? {a_q, b0_q} : {b1_q, a_q};
      end
      default: ;
    endcase
  end

  srm_ram #(.DATA_W(NBR_W), .DEPTH(NUM_NODES)) u_nbr_ram (
    .clk_i   (clk_i),
    .we_i    (nbr_we),
    .waddr_i (nbr_waddr),
    .wdata_i (nbr_wdata),
    .raddr_i (rd_addr_d),
    .rdata_o (nbr_rdata)
  );

  srm_ram #(.DATA_W(DEM_W), .DEPTH(NUM_NODES)) u_dem_ram (
    .clk_i   (clk_i),
    .we_i    (dem_we),
    .waddr_i (node_a_i),
    .wdata_i (demand_value_i),
    .raddr_i (rd_addr_d),
    .rdata_o (dem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_q       <= '0;
      prev_q       <= '0;
      a_q          <= '0;
      b_q          <= '0;
      a0_q         <= '0;
      a1_q         <= '0;
      b0_q         <= '0;
      b1_q         <= '0;
      end_a_q      <= '0;
      end_b_q      <= '0;
      sa_q         <= 1'b0;
      sb_q         <= 1'b0;
      first_q      <= 1'b0;
      apply_q      <= 1'b0;
      steps_q      <= '0;
      saving_q     <= '0;
      acc_q        <= '0;
      total_q      <= '0;
      cap_q        <= CAP_RESET;
      status_q     <= ST_INVALID;
      nbr_vld_q    <= '0;
      dem_vld_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_INVALID;
      out_demand_q <= '0;
      out_total_q  <= '0;
    end else begin
      node_q <= rd_addr_d;
      if (cfg_valid_i && cfg_ready_o) cap_q <= cfg_vehicle_capacity_i;
      if (out_valid_q && !out_stall_i && state_q != S_FINISH) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            a_q      <= node_a_i;
            b_q      <= node_b_i;
            saving_q <= saving_i;
            apply_q  <= apply_if_feasible_i;
            acc_q    <= '0;
            if (operation_i == OP_LOAD) begin
              status_q <= a_range_ok ? ST_LOADED : ST_INVALID;
              if (a_range_ok) dem_vld_q[node_a_i] <= 1'b1;
              state_q <= S_FINISH;
            end else if (merge_bad) begin
              status_q <= ST_INVALID;
              state_q  <= S_FINISH;
            end else begin
              state_q <= S_RD_A;
            end
          end
        end
        S_RD_A: begin
          a0_q    <= nb0;
          a1_q    <= nb1;
          state_q <= S_RD_B;
        end
        S_RD_B: begin
          b0_q    <= nb0;
          b1_q    <= nb1;
          sa_q    <= (a0_q != '0);
          sb_q    <= (nb0 != '0);
          first_q <= 1'b1;
          steps_q <= '0;
          if ((a0_q != '0 && a1_q != '0) || (nb0 != '0 && nb1 != '0)) begin
            status_q <= ST_INTERIOR;
            state_q  <= S_FINISH;
          end else if (a_other == b_q || b_other == a_q) begin
            status_q <= ST_LINKED;
            state_q  <= S_FINISH;
          end else begin
            state_q <= S_WALK_A;
          end
        end
        S_WALK_A, S_WALK_B: begin
          acc_q <= acc_sat;
          if (walk_cont) begin
            prev_q  <= node_q;
            first_q <= 1'b0;
            steps_q <= steps_nxt;
          end else if (state_q == S_WALK_A) begin
            end_a_q <= node_q;
            first_q <= 1'b1;
            steps_q <= '0;
            state_q <= S_WALK_B;
          end else begin
            end_b_q <= node_q;
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state_q <= S_FINISH;
          if (end_a_q == b_q || end_b_q == a_q) begin
            status_q <= ST_SAME;
          end else if (acc_q >= cap_q) begin
            status_q <= ST_OVER_CAP;
          end else if (!sav_pos) begin
            status_q <= ST_NONPOS;
          end else if (apply_q) begin
            status_q <= ST_MERGED;
            total_q  <= tot_sat;
            state_q  <= S_WR_A;
          end else begin
            status_q <= ST_FEASIBLE;
          end
        end
        S_WR_A: begin
          nbr_vld_q[a_q] <= 1'b1;
          state_q        <= S_WR_B;
        end
        S_WR_B: begin
          nbr_vld_q[b_q] <= 1'b1;
          state_q        <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_demand_q <= acc_q;
            out_total_q  <= total_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign route_demand_o = out_demand_q;
  assign total_saved_o  = out_total_q;

  // busy right after every input transfer
  `SRM_ASSERT(a_busy_after_xfer, clk_i, rst_ni, in_xfer |=> in_stall_o)
  // route walk never exceeds the node count
  `SRM_ASSERT_ALWAYS(a_walk_bound, clk_i, steps_q <= STEP_LIM)
  // saturating total never goes down
  `SRM_ASSERT(a_total_mono, clk_i, rst_ni, 1'b1 |=> total_q >= $past(total_q))
  // a result only appears out of the finish step
  `SRM_ASSERT(a_out_from_finish, clk_i, rst_ni,
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
  // table writes only in the two commit steps
  `SRM_ASSERT(a_nbr_write, clk_i, rst_ni,
    nbr_we |-> (state_q == S_WR_A || state_q == S_WR_B))

endmodule
